/* sv/mbea_pkg.sv */
// ----------------------------------------------------------------------------
// mbea_pkg
// Shared types and constants for the multi-board e-stop aggregator.
// ----------------------------------------------------------------------------
package mbea_pkg;

  // Item kinds carried on s_tuser
  typedef enum logic [1:0] {
    ACT_REPORT    = 2'd0,
    ACT_TICK      = 2'd1,
    ACT_COORD     = 2'd2,
    ACT_RESET_REQ = 2'd3
  } action_t;

  // Reasons a reset request is refused
  typedef enum logic [1:0] {
    CAUSE_NONE  = 2'd0,
    CAUSE_ESTOP = 2'd1,
    CAUSE_STALE = 2'd2,
    CAUSE_LEVEL = 2'd3
  } cause_t;

  // Configuration register indexes
  localparam logic [1:0] REG_AUTO_RESET = 2'd0;
  localparam logic [1:0] REG_TIMEOUT    = 2'd1;
  localparam logic [1:0] REG_CRITICAL   = 2'd2;

  // Configuration reset values
  localparam logic        AUTO_RESET_INIT = 1'b0;
  localparam logic [15:0] TIMEOUT_INIT    = 16'd2000;
  localparam logic [7:0]  CRITICAL_INIT   = 8'd2;

  // Coordination command code that raises the stop
  localparam logic EMERG_CMD_CODE = 1'b1;

  // Controller to datapath commands
  typedef struct packed {
    logic accept;   // latch the input beat, clear accumulators
    logic update;   // store a report or advance time
    logic scan_rd;  // read table entry at the scan address
    logic finish;   // form the result and load the output register
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic out_busy; // output register holds a beat that is not taken this cycle
  } sts_t;

  // One result beat
  typedef struct packed {
    logic [3:0] deny_board;
    cause_t     deny_cause;
    logic       reset_ok;
    logic       new_timeout;
    logic       stop_changed;
    logic       global_stop;
  } res_t;

endpackage

/* sv/mbea_ctrl.sv */
// ----------------------------------------------------------------------------
// mbea_ctrl
// Sequencer: accepts one item, walks the board table once (a coordination
// command skips the walk), then hands the result to the output register.
// ----------------------------------------------------------------------------
module mbea_ctrl #(
  parameter int BOARDS = 16,
  parameter int IW     = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [1:0]        s_tuser,   // [1:0] action
  input  mbea_pkg::sts_t    sts,
  output mbea_pkg::cmd_t    cmd,
  output logic [IW-1:0]     rd_addr
);
  import mbea_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UPDATE,
    S_SCAN,
    S_DRAIN,
    S_FINISH
  } state_t;

  localparam logic [IW-1:0] LAST = IW'(BOARDS - 1);

  state_t        state;
  logic [IW-1:0] cnt;
  logic          in_acc;
  action_t       in_act;

  assign in_act   = action_t'(s_tuser);
  assign s_tready = (state == S_IDLE);
  assign in_acc   = s_tvalid && s_tready;
  assign rd_addr  = cnt;

  // Command decode
  always_comb begin
    cmd.accept  = in_acc;
    cmd.update  = (state == S_UPDATE);
    cmd.scan_rd = (state == S_SCAN);
    cmd.finish  = (state == S_FINISH) && !sts.out_busy;
  end

  // State register and scan counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          cnt <= '0;
          if (in_acc) begin
            case (in_act)
              ACT_REPORT, ACT_TICK: state <= S_UPDATE;
              ACT_RESET_REQ:        state <= S_SCAN;
              default:              state <= S_FINISH;
            endcase
          end
        end
        S_UPDATE: state <= S_SCAN;
        S_SCAN: begin
          if (cnt == LAST) begin
            state <= S_DRAIN;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_DRAIN: state <= S_FINISH;
        S_FINISH: begin
          if (!sts.out_busy) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* sv/mbea_datapath.sv */
// ----------------------------------------------------------------------------
// mbea_datapath
// Board table, time base, configuration registers, scan accumulators and the
// output register.
// ----------------------------------------------------------------------------
module mbea_datapath #(
  parameter int BOARDS = 16,
  parameter int IW     = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [15:0]       cfg_data,
  input  logic [15:0]       s_tdata,   // [3:0] board_index, [4] board_estop,
                                       // [12:5] board_level, [13] is_emergency
  input  logic [1:0]        s_tuser,   // [1:0] action
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [15:0]       m_tdata,   // [0] global_stop, [1] stop_changed,
                                       // [2] new_timeout, [3] reset_ok,
                                       // [5:4] deny_cause, [9:6] deny_board
  input  mbea_pkg::cmd_t    cmd,
  input  logic [IW-1:0]     rd_addr,
  output mbea_pkg::sts_t    sts
);
  import mbea_pkg::*;

  localparam int EW = 42; // estop, level, stale, stamp

  // Configuration registers
  logic        auto_reset;
  logic [15:0] timeout_ticks;
  logic [7:0]  critical_level;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      auto_reset     <= AUTO_RESET_INIT;
      timeout_ticks  <= TIMEOUT_INIT;
      critical_level <= CRITICAL_INIT;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_AUTO_RESET: auto_reset     <= cfg_data[0];
        REG_TIMEOUT:    timeout_ticks  <= cfg_data;
        REG_CRITICAL:   critical_level <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Latched item
  action_t    act;
  logic [3:0] bidx;
  logic       best;
  logic [7:0] blvl;
  logic       bemg;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      act  <= action_t'(s_tuser);
      bidx <= s_tdata[3:0];
      best <= s_tdata[4];
      blvl <= s_tdata[12:5];
      bemg <= s_tdata[13];
    end
  end

  // Report address and range check
  logic [8:0]    bidx9;
  logic          in_range;
  logic [IW-1:0] rep_addr;

  assign bidx9    = 9'(bidx);
  assign in_range = bidx9 < 9'(BOARDS);
  assign rep_addr = bidx9[IW-1:0];

  // Table: valid bits in flops, entry data in memory
  logic [BOARDS-1:0] valid;
  logic [EW-1:0]     mem [BOARDS];
  logic [EW-1:0]     rdata;
  logic              rd_vld;
  logic [IW-1:0]     rd_idx;
  logic [31:0]       time_now;

  logic              we;
  logic [IW-1:0]     wa;
  logic [EW-1:0]     wd;

  // Entry fields of the beat under evaluation
  logic        e_valid;
  logic        e_estop;
  logic [7:0]  e_level;
  logic        e_stale;
  logic [31:0] e_stamp;
  logic [31:0] age;
  logic        newly;
  logic        stale_eff;
  logic        blocks;
  cause_t      cause_now;

  always_comb begin
    e_valid   = valid[rd_idx];
    e_estop   = rdata[41];
    e_level   = rdata[40:33];
    e_stale   = rdata[32];
    e_stamp   = rdata[31:0];
    age       = time_now - e_stamp;
    newly     = rd_vld && (act == ACT_TICK) && e_valid && !e_stale &&
                (age > {16'd0, timeout_ticks});
    stale_eff = e_stale || newly;
    blocks    = e_valid && (e_estop || stale_eff || (e_level >= critical_level));
    if (!e_valid) begin
      cause_now = CAUSE_NONE;
    end else if (e_estop) begin
      cause_now = CAUSE_ESTOP;
    end else if (e_stale) begin
      cause_now = CAUSE_STALE;
    end else if (e_level >= critical_level) begin
      cause_now = CAUSE_LEVEL;
    end else begin
      cause_now = CAUSE_NONE;
    end
  end

  // Write port: report store, or stale mark written back during a tick scan
  always_comb begin
    we = 1'b0;
    wa = rep_addr;
    wd = {best, blvl, 1'b0, time_now};
    if (cmd.update && (act == ACT_REPORT) && in_range) begin
      we = 1'b1;
    end else if (newly) begin
      we = 1'b1;
      wa = rd_idx;
      wd = {e_estop, e_level, 1'b1, e_stamp};
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (cmd.scan_rd) begin
      rdata <= mem[rd_addr];
    end
    rd_idx <= rd_addr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      time_now <= '0;
      rd_vld   <= 1'b0;
    end else begin
      rd_vld <= cmd.scan_rd;
      if (cmd.update && (act == ACT_REPORT) && in_range) begin
        valid[rep_addr] <= 1'b1;
      end
      if (cmd.update && (act == ACT_TICK)) begin
        time_now <= time_now + 32'd1;
      end
    end
  end

  // Scan accumulators
  logic          demand;
  logic          newto;
  cause_t        cause_acc;
  logic [IW-1:0] board_acc;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      demand    <= 1'b0;
      newto     <= 1'b0;
      cause_acc <= CAUSE_NONE;
      board_acc <= '0;
    end else if (rd_vld) begin
      demand <= demand || blocks;
      newto  <= newto || newly;
      if ((cause_acc == CAUSE_NONE) && (cause_now != CAUSE_NONE)) begin
        cause_acc <= cause_now;
        board_acc <= rd_idx;
      end
    end
  end

  // Result formation
  logic       stop;
  logic       stop_next;
  logic       granted;
  logic [8:0] board9;
  res_t       res_next;
  res_t       res;

  assign board9 = 9'(board_acc);

  always_comb begin
    granted   = 1'b0;
    stop_next = stop;
    case (act)
      ACT_REPORT, ACT_TICK: stop_next = demand;
      ACT_COORD:            stop_next = stop || (bemg == EMERG_CMD_CODE);
      ACT_RESET_REQ: begin
        granted = (cause_acc == CAUSE_NONE) || auto_reset;
        if (granted) begin
          stop_next = 1'b0;
        end
      end
      default: stop_next = stop;
    endcase
    res_next.global_stop  = stop_next;
    res_next.stop_changed = stop_next != stop;
    res_next.new_timeout  = (act == ACT_TICK) && newto;
    res_next.reset_ok     = granted;
    res_next.deny_cause   = ((act == ACT_RESET_REQ) && !granted) ? cause_acc : CAUSE_NONE;
    res_next.deny_board   = ((act == ACT_RESET_REQ) && !granted) ? board9[3:0] : 4'd0;
  end

  // Stop flag and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      stop     <= 1'b0;
      m_tvalid <= 1'b0;
    end else if (cmd.finish) begin
      stop     <= stop_next;
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      res <= res_next;
    end
  end

  assign sts.out_busy = m_tvalid && !m_tready;
  assign m_tdata      = {6'd0, res};

`ifndef SYNTHESIS
  // A granted reset never carries a denial cause or board
  a_grant_clean: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && res.reset_ok) |-> (res.deny_cause == CAUSE_NONE && res.deny_board == 4'd0))
    else $error("granted reset carries denial info");

  // A newly stale board always leaves the stop raised
  a_timeout_stop: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && res.new_timeout) |-> res.global_stop)
    else $error("new timeout without global stop");

  // A denied reset leaves the stop flag as it was
  a_deny_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && res.deny_cause != CAUSE_NONE) |-> !res.stop_changed)
    else $error("denied reset changed the stop");

  // Writes into the table only land inside it
  a_write_range: assert property (@(posedge clk) disable iff (rst)
    we |-> (9'(wa) < 9'(BOARDS)))
    else $error("table write out of range");
`endif

endmodule

/* sv/multi_board_estop_aggregator_unit.sv */
// ----------------------------------------------------------------------------
// multi_board_estop_aggregator_unit
// Global emergency-stop aggregator over a table of board status entries.
// ----------------------------------------------------------------------------
// Each input beat is one of four kinds (s_tuser): a board status report, a
// time tick, a coordination command, or a reset request. Every beat yields
// exactly one result beat. Reports, ticks and reset requests walk the whole
// board table once through a single-port read of the entry memory, one entry
// per cycle, before the result beat is formed (a reset request skips the
// update step); a coordination command goes straight to forming its result.
// The next input beat can be accepted in the cycle after the result is
// loaded. One item is in flight at a time; a finished result waits in the
// output register while the next item is already accepted, and that item
// stalls in its last step until the output register is free. After reset
// the table is empty (all boards invalid), time is zero and the stop is
// clear. Configuration writes are always ready and must only be issued
// while the block is idle.
module multi_board_estop_aggregator_unit #(
  parameter int BOARDS = 16
) (
  input  logic        clk,
  input  logic        rst,
  // configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [3:0] board_index, [4] board_estop,
                                 // [12:5] board_level, [13] is_emergency
  input  logic [1:0]  s_tuser,   // [1:0] action
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata    // [0] global_stop, [1] stop_changed,
                                 // [2] new_timeout, [3] reset_ok,
                                 // [5:4] deny_cause, [9:6] deny_board
);
  import mbea_pkg::*;

  localparam int IW = (BOARDS > 1) ? $clog2(BOARDS) : 1;

  cmd_t          cmd;
  sts_t          sts;
  logic [IW-1:0] rd_addr;

  mbea_ctrl #(
    .BOARDS (BOARDS),
    .IW     (IW)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .sts      (sts),
    .cmd      (cmd),
    .rd_addr  (rd_addr)
  );

  mbea_datapath #(
    .BOARDS (BOARDS),
    .IW     (IW)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cmd       (cmd),
    .rd_addr   (rd_addr),
    .sts       (sts)
  );

endmodule
